>>> src/assert_macros.svh
// Assertion macros shared by the glyph slot cache RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gslc: property failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gslc: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

>>> src/gslc_pkg.sv
// Shared constants and controller/datapath interface types for the glyph slot cache.
// No dependencies.
package gslc_pkg;

  localparam int unsigned CODE_W          = 21;
  localparam int unsigned SLOT_OUT_W      = 8;
  localparam int unsigned MISS_W          = 16;
  localparam logic [MISS_W-1:0] MISS_MAX  = 16'hFFFF;

  localparam int unsigned SLOT_COUNT_DEF  = 256;
  localparam int unsigned STAMP_BITS_DEF  = 16;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;   // write a zero entry at the sweep pointer
    logic accept;  // latch the incoming item
    logic scan;    // read the next entry, evaluate the previous one
    logic commit;  // write back the chosen slot and load the result
  } gslc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;   // sweep pointer at the last slot
    logic scan_done;  // hit found or last slot evaluated
    logic out_free;   // result register can take a new result
  } gslc_status_t;

endpackage

>>> src/gslc_ctrl.sv
// Controller state machine for the glyph slot cache: clearing sweep, idle, scan, commit.
// Depends on gslc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gslc_ctrl import gslc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  gslc_status_t status_i,
  output gslc_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_COMMIT) && status_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_PROP(a_accept_starts_scan, clk_i, rst_ni, cmd_o.accept |=> state_q == ST_SCAN)
  `ASSERT_PROP(a_sweep_once, clk_i, rst_ni, state_q != ST_CLEAR |=> state_q != ST_CLEAR)

endmodule

>>> src/gslc_datapath.sv
// Datapath of the glyph slot cache: slot memory, scan and victim search, stamps, result register.
// Depends on gslc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gslc_datapath import gslc_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gslc_cmd_t             cmd_i,
  output gslc_status_t          status_o,
  input  logic [CODE_W-1:0]     char_code_i,
  input  logic                  string_first_i,
  input  logic                  string_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic                  hit_o,
  output logic                  evicted_valid_o,
  output logic [CODE_W-1:0]     evicted_code_o,
  output logic [MISS_W-1:0]     string_misses_o,
  output logic                  string_done_o
);

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned ENTRY_W = 1 + CODE_W + STAMP_BITS;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOT_COUNT - 1);

  // entry: {valid, code, stamp}
  logic [ENTRY_W-1:0] mem_q [SLOT_COUNT];
  logic [ENTRY_W-1:0] rd_data_q;

  logic [IDX_W-1:0]      rd_addr_q;
  logic [IDX_W-1:0]      chk_addr_q;
  logic                  chk_vld_q;
  logic                  chk_last_q;
  logic [STAMP_BITS-1:0] next_stamp_q;
  logic [STAMP_BITS-1:0] string_stamp_q;
  logic [MISS_W-1:0]     miss_cnt_q;

  logic [CODE_W-1:0]     item_code_q;
  logic                  item_last_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      sel_q;
  logic [IDX_W-1:0]      vic_q;
  logic                  vic_valid_q;
  logic [CODE_W-1:0]     vic_code_q;
  logic [STAMP_BITS-1:0] min_stamp_q;

  logic                  out_valid_q;
  logic [SLOT_OUT_W-1:0] slot_index_q;
  logic                  hit_out_q;
  logic                  ev_valid_q;
  logic [CODE_W-1:0]     ev_code_q;
  logic [MISS_W-1:0]     misses_out_q;
  logic                  done_out_q;

  logic                  ent_valid;
  logic [CODE_W-1:0]     ent_code;
  logic [STAMP_BITS-1:0] ent_stamp;
  logic                  eval;
  logic                  match;
  logic                  take_min;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]      commit_idx;
  logic [IDX_W+SLOT_OUT_W-1:0] idx_wide;
  logic [MISS_W-1:0]     miss_inc;

  assign ent_valid = rd_data_q[ENTRY_W-1];
  assign ent_code  = rd_data_q[STAMP_BITS +: CODE_W];
  assign ent_stamp = rd_data_q[STAMP_BITS-1:0];

  assign eval     = cmd_i.scan && chk_vld_q;
  assign match    = eval && ent_valid && (ent_code == item_code_q);
  // strict less-than keeps the lowest-numbered slot among equal minima
  assign take_min = eval && !match && ((chk_addr_q == '0) || (ent_stamp < min_stamp_q));

  assign status_o.clr_last  = (rd_addr_q == LastIdx);
  assign status_o.scan_done = eval && (match || chk_last_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign commit_idx = hit_q ? sel_q : vic_q;
  assign idx_wide   = {{SLOT_OUT_W{1'b0}}, commit_idx};
  assign miss_inc   = (miss_cnt_q == MISS_MAX) ? miss_cnt_q : miss_cnt_q + MISS_W'(1);

  assign mem_we    = cmd_i.clear || cmd_i.commit;
  assign mem_waddr = cmd_i.clear ? rd_addr_q : commit_idx;
  assign mem_wdata = cmd_i.clear ? '0 : {1'b1, item_code_q, string_stamp_q};

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.scan) rd_data_q <= mem_q[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q      <= '0;
      chk_vld_q      <= 1'b0;
      chk_last_q     <= 1'b0;
      next_stamp_q   <= STAMP_BITS'(1);
      string_stamp_q <= '0;
      miss_cnt_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        rd_addr_q <= '0;
        chk_vld_q <= 1'b0;
        if (string_first_i) begin
          string_stamp_q <= next_stamp_q;
          next_stamp_q   <= next_stamp_q + STAMP_BITS'(1);
          miss_cnt_q     <= '0;
        end
      end else begin
        if (cmd_i.clear || cmd_i.scan) begin
          rd_addr_q <= (rd_addr_q == LastIdx) ? '0 : rd_addr_q + IDX_W'(1);
        end
        chk_vld_q <= cmd_i.scan;
        if (cmd_i.scan) chk_last_q <= (rd_addr_q == LastIdx);
      end
      if (cmd_i.commit && !hit_q) miss_cnt_q <= miss_inc;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_code_q <= char_code_i;
      item_last_q <= string_last_i;
      hit_q       <= 1'b0;
    end
    if (cmd_i.scan) chk_addr_q <= rd_addr_q;
    if (match) begin
      hit_q <= 1'b1;
      sel_q <= chk_addr_q;
    end
    if (take_min) begin
      min_stamp_q <= ent_stamp;
      vic_q       <= chk_addr_q;
      vic_valid_q <= ent_valid;
      vic_code_q  <= ent_code;
    end
    if (cmd_i.commit) begin
      slot_index_q <= idx_wide[SLOT_OUT_W-1:0];
      hit_out_q    <= hit_q;
      ev_valid_q   <= !hit_q && vic_valid_q;
      ev_code_q    <= (!hit_q && vic_valid_q) ? vic_code_q : '0;
      misses_out_q <= hit_q ? miss_cnt_q : miss_inc;
      done_out_q   <= item_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_index_o    = slot_index_q;
  assign hit_o           = hit_out_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_code_o  = ev_code_q;
  assign string_misses_o = misses_out_q;
  assign string_done_o   = done_out_q;

  `ASSERT_PROP(a_commit_when_free, clk_i, rst_ni, cmd_i.commit |-> status_o.out_free)
  `ASSERT_NEVER(a_hit_with_evict, clk_i, rst_ni, out_valid_q && hit_out_q && ev_valid_q)

endmodule

>>> src/glyph_slot_lru_cache_top.sv
// Top level of the glyph slot cache: controller plus datapath.
// Depends on gslc_pkg, gslc_ctrl and gslc_datapath.
//
// Fully associative cache mapping 21-bit code points to texture slots, with
// timestamp LRU replacement.
// Input channel: in_valid_i / in_stall_o carry one code point per item with
//   string_first_i / string_last_i marks. An item is taken when valid is high
//   and stall is low.
// Output channel: out_valid_o / out_stall_i carry one result per item: slot,
//   hit, evicted code and the running miss count of the string.
// Sequence: the item is taken, then a scan reads one slot entry per cycle
//   through the single read port of the slot memory, then a commit writes the
//   chosen slot and loads the result. A hit in slot k ends the scan early; a
//   miss scans every slot.
// Throughput: one item at a time; the next item is taken once the previous
//   one has committed, even while its result still waits in the output register.
// Reset: a clearing sweep writes every slot entry to zero, with in_stall_o
//   high throughout.
// Receiver stall: the result holds in the output register; a further item may
//   be scanned but commits only when that register has been taken.

module glyph_slot_lru_cache_top import gslc_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CODE_W-1:0]     char_code_i,
  input  logic                  string_first_i,
  input  logic                  string_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic                  hit_o,
  output logic                  evicted_valid_o,
  output logic [CODE_W-1:0]     evicted_code_o,
  output logic [MISS_W-1:0]     string_misses_o,
  output logic                  string_done_o
);

  gslc_cmd_t    cmd;
  gslc_status_t status;

  gslc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gslc_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .char_code_i     (char_code_i),
    .string_first_i  (string_first_i),
    .string_last_i   (string_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .slot_index_o    (slot_index_o),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_code_o  (evicted_code_o),
    .string_misses_o (string_misses_o),
    .string_done_o   (string_done_o)
  );

endmodule
